@@ design/tcdb_pkg.sv @@
`timescale 1ns / 1ps

package tcdb_pkg;

  typedef struct packed {
    logic [7:0] tag_id;
    logic [9:0] corner0_x;
    logic [9:0] corner0_y;
    logic [9:0] corner1_x;
    logic [9:0] corner1_y;
    logic [9:0] corner2_x;
    logic [9:0] corner2_y;
    logic [9:0] corner3_x;
    logic [9:0] corner3_y;
  } in_t;

  typedef struct packed {
    logic [7:0]         tag_id_out;
    logic [15:0]        range_q8;
    logic signed [15:0] bearing_centideg;
    logic [14:0]        mean_edge_q4;
    logic               tag_ok;
    logic               degenerate;
  } out_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_FOCAL  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SIZE   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TRIM   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CENTER = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_VEDGE  = 3'd4;

  localparam logic [9:0]         FOCAL_RST  = 10'd172;
  localparam logic [15:0]        SIZE_RST   = 16'd256;
  localparam logic signed [14:0] TRIM_RST   = 15'sd380;
  localparam logic [9:0]         CENTER_RST = 10'd160;
  localparam logic [8:0]         VEDGE_RST  = 9'd20;

  localparam int AtanW = 23;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [AtanW-1:0] atan_q16(input int i);
    logic [AtanW-1:0] r;
    r = '0;
    case (i)
      0:  r = 23'd2949120;
      1:  r = 23'd1740967;
      2:  r = 23'd919879;
      3:  r = 23'd466945;
      4:  r = 23'd234379;
      5:  r = 23'd117304;
      6:  r = 23'd58666;
      7:  r = 23'd29335;
      8:  r = 23'd14668;
      9:  r = 23'd7334;
      10: r = 23'd3667;
      11: r = 23'd1833;
      12: r = 23'd917;
      13: r = 23'd458;
      14: r = 23'd229;
      15: r = 23'd115;
      16: r = 23'd57;
      17: r = 23'd29;
      18: r = 23'd14;
      19: r = 23'd7;
      20: r = 23'd4;
      21: r = 23'd2;
      22: r = 23'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ design/tag_corner_distance_bearing_top.sv @@
`timescale 1ns / 1ps
// RW = (2*COORD_BITS+10)/2 is the width of each edge root.
// Throughput: one beat per cycle; every stage holds while the output beat is stalled.
// Stages: edge differences, squares, one stage per root bit (sqrt), a CORDIC stage per
// step in parallel, a setup stage, one stage per quotient bit (range divide), output
// format. Reset (rst, synchronous, active high) clears all stage valid bits and loads
// the register defaults.
module tag_corner_distance_bearing_top #(
  parameter int COORD_BITS   = 10,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  tcdb_pkg::in_t            in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output tcdb_pkg::out_t           out_data,
  input  logic                     cfg_we,
  input  logic [tcdb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tcdb_pkg::CfgDataW-1:0] cfg_data
);
  import tcdb_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int CS   = CORDIC_STEPS;
  localparam int DW   = CB + 1;
  localparam int SQW  = 2 * CB + 1;
  localparam int RW   = (SQW + 9) / 2;
  localparam int VW   = 2 * RW;
  localparam int REMW = RW + 3;
  localparam int OW   = ((CB + 2 > 12) ? CB + 2 : 12) + 1;
  localparam int CW   = OW + 18;
  localparam int ZW   = 25;
  localparam int DVW  = (RW + 17 > 32) ? RW + 17 : 32;
  localparam int PW   = 26;
  localparam int NST  = RW + 20;

  typedef struct packed {
    logic                 vld;
    logic [7:0]           tag;
    logic [3:0][DW-1:0]   dx;
    logic [3:0][DW-1:0]   dy;
    logic signed [OW-1:0] off;
    logic [3:0][VW-1:0]   v;
    logic [3:0][REMW-1:0] rem;
    logic [3:0][RW-1:0]   root;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zf;
    logic [RW+1:0]        sum;
    logic [RW:0]          tb;
    logic [DVW-1:0]       dr;
    logic [15:0]          q;
    logic                 ovf;
    logic                 deg;
    logic signed [16:0]   cd;
    logic [15:0]          rng;
    logic signed [15:0]   brg;
    logic [14:0]          mn;
    logic                 tv;
  } stg_t;

  logic [9:0]         focal;
  logic [15:0]        tsize;
  logic signed [14:0] trim;
  logic [9:0]         center;
  logic [8:0]         vedge;
  logic [PW-1:0]      prod;

  stg_t st [NST];
  stg_t nx [NST];
  logic adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal  <= FOCAL_RST;
      tsize  <= SIZE_RST;
      trim   <= TRIM_RST;
      center <= CENTER_RST;
      vedge  <= VEDGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOCAL:  focal  <= cfg_data[9:0];
        REG_SIZE:   tsize  <= cfg_data;
        REG_TRIM:   trim   <= $signed(cfg_data[14:0]);
        REG_CENTER: center <= cfg_data[9:0];
        REG_VEDGE:  vedge  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= PW'(focal) * PW'(tsize);
  end

  assign adv      = !(st[NST-1].vld && out_stall);
  assign in_stall = !adv;

  always_comb begin
    logic [CB-1:0]        cx [4];
    logic [CB-1:0]        cy [4];
    logic [CB+1:0]        sumx;
    logic signed [DW-1:0] ax, ay;
    logic [2*DW:0]        sqs;
    logic [REMW-1:0]      rm, tr;
    logic signed [CW-1:0] xs, ys;
    logic [DVW-1:0]       dt;
    logic signed [ZW+7:0] zm;
    logic signed [17:0]   bb;
    logic [RW-1:0]        mq;
    stg_t                 p;
    cx[0] = CB'(in_data.corner0_x);
    cy[0] = CB'(in_data.corner0_y);
    cx[1] = CB'(in_data.corner1_x);
    cy[1] = CB'(in_data.corner1_y);
    cx[2] = CB'(in_data.corner2_x);
    cy[2] = CB'(in_data.corner2_y);
    cx[3] = CB'(in_data.corner3_x);
    cy[3] = CB'(in_data.corner3_y);
    ax = '0; ay = '0; sqs = '0; rm = '0; tr = '0; xs = '0; ys = '0;
    dt = '0; zm = '0; bb = '0; mq = '0;

    // edges: top 1-0, bottom 3-2, left 0-3, right 1-2
    nx[0] = st[0];
    nx[0].vld = in_valid;
    nx[0].tag = in_data.tag_id;
    nx[0].dx[0] = DW'(cx[1]) - DW'(cx[0]);
    nx[0].dy[0] = DW'(cy[1]) - DW'(cy[0]);
    nx[0].dx[1] = DW'(cx[3]) - DW'(cx[2]);
    nx[0].dy[1] = DW'(cy[3]) - DW'(cy[2]);
    nx[0].dx[2] = DW'(cx[0]) - DW'(cx[3]);
    nx[0].dy[2] = DW'(cy[0]) - DW'(cy[3]);
    nx[0].dx[3] = DW'(cx[1]) - DW'(cx[2]);
    nx[0].dy[3] = DW'(cy[1]) - DW'(cy[2]);
    sumx = (CB+2)'(cx[0]) + (CB+2)'(cx[1]) + (CB+2)'(cx[2]) + (CB+2)'(cx[3]);
    nx[0].off = $signed(OW'(sumx)) - $signed(OW'({center, 2'b00}));

    for (int k = 1; k < NST; k++) begin
      p = st[k-1];
      nx[k] = p;
      if (k == 1) begin
        for (int e = 0; e < 4; e++) begin
          ax = $signed(p.dx[e]);
          ay = $signed(p.dy[e]);
          sqs = (2*DW+1)'(ax * ax) + (2*DW+1)'(ay * ay);
          nx[k].v[e]    = VW'(sqs) << 8;
          nx[k].rem[e]  = '0;
          nx[k].root[e] = '0;
        end
        nx[k].x  = $signed(CW'({focal, 18'b0}));
        nx[k].y  = CW'(p.off) <<< 16;
        nx[k].z  = '0;
        nx[k].zf = (focal == '0) && (p.off == '0);
      end
      if (k >= 2 && k <= RW + 1) begin
        for (int e = 0; e < 4; e++) begin
          rm = {p.rem[e][REMW-3:0], p.v[e][VW-1:VW-2]};
          tr = REMW'({p.root[e], 2'b01});
          nx[k].v[e] = p.v[e] << 2;
          if (rm >= tr) begin
            nx[k].rem[e]  = rm - tr;
            nx[k].root[e] = {p.root[e][RW-2:0], 1'b1};
          end else begin
            nx[k].rem[e]  = rm;
            nx[k].root[e] = {p.root[e][RW-2:0], 1'b0};
          end
        end
      end
      if (k >= 2 && k <= CS + 1) begin
        xs = p.x >>> (k - 2);
        ys = p.y >>> (k - 2);
        if (!p.y[CW-1]) begin
          nx[k].x = p.x + ys;
          nx[k].y = p.y - xs;
          nx[k].z = p.z + $signed(ZW'(atan_q16(k - 2)));
        end else begin
          nx[k].x = p.x - ys;
          nx[k].y = p.y + xs;
          nx[k].z = p.z - $signed(ZW'(atan_q16(k - 2)));
        end
      end
      if (k == RW + 2) begin
        nx[k].sum = (RW+2)'(p.root[0]) + (RW+2)'(p.root[1])
                  + (RW+2)'(p.root[2]) + (RW+2)'(p.root[3]);
        nx[k].tb  = (RW+1)'(p.root[0]) + (RW+1)'(p.root[1]);
        nx[k].deg = (nx[k].tb == '0);
        nx[k].dr  = DVW'({prod, 5'b0}) + DVW'(nx[k].tb >> 1);
        nx[k].ovf = nx[k].dr >= (DVW'(nx[k].tb) << 16);
        nx[k].q   = '0;
      end
      if (k >= RW + 3 && k <= RW + 18) begin
        dt = DVW'(p.tb) << (RW + 18 - k);
        if (p.dr >= dt) begin
          nx[k].dr = p.dr - dt;
          nx[k].q[RW + 18 - k] = 1'b1;
        end
      end
      if (k == RW + 18) begin
        zm = (p.zf ? (ZW+8)'(0) : (ZW+8)'(p.z)) * $signed(8'sd100)
           + $signed((ZW+8)'(32768));
        nx[k].cd = $signed(zm[ZW+7:16]);
      end
      if (k == RW + 19) begin
        nx[k].rng = p.ovf ? 16'hffff : p.q;
        mq = p.sum[RW+1:2];
        nx[k].mn = (mq > RW'(32767)) ? 15'h7fff : 15'(mq);
        nx[k].tv = nx[k].mn > {2'b00, vedge, 4'b0000};
        bb = 18'(p.cd) - 18'(trim);
        if (bb > 18'sd18000) begin
          nx[k].brg = 16'sd18000;
        end else if (bb < -18'sd18000) begin
          nx[k].brg = -16'sd18000;
        end else begin
          nx[k].brg = 16'(bb);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) begin
        st[k].vld <= 1'b0;
      end
    end else if (adv) begin
      st <= nx;
    end
  end

  assign out_valid                 = st[NST-1].vld;
  assign out_data.tag_id_out       = st[NST-1].tag;
  assign out_data.range_q8         = st[NST-1].rng;
  assign out_data.bearing_centideg = st[NST-1].brg;
  assign out_data.mean_edge_q4     = st[NST-1].mn;
  assign out_data.tag_ok           = st[NST-1].tv;
  assign out_data.degenerate       = st[NST-1].deg;

endmodule

@@ design/tcdb_chk.sv @@
`timescale 1ns / 1ps
module tcdb_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input tcdb_pkg::out_t                out_data
);
  import tcdb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_hold_all: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output hold");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |-> out_data.range_q8 == 16'hffff)
    else $error("degenerate tag without saturated range");

  a_bearing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_data.bearing_centideg) <= 16'sd18000) &&
                  ($signed(out_data.bearing_centideg) >= -16'sd18000))
    else $error("bearing out of range");

  a_valid_edge: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.tag_ok |-> out_data.mean_edge_q4 != 15'd0)
    else $error("valid tag with zero mean edge");

endmodule

bind tag_corner_distance_bearing_top tcdb_chk u_tcdb_chk (.*);
